>>> rtl/tcd_pkg.sv
// Shared constants, state encoding and divider interface types for the centroid defuzzifier.
`default_nettype none

package tcd_pkg;

  localparam int COORD_BITS      = 16;
  localparam int SLOPE_BITS      = COORD_BITS - 1;
  localparam int LEVEL_W         = 16;
  localparam int LEVEL_FRAC_BITS = 15;
  localparam int OUT_FRAC_BITS   = 8;
  localparam int GEO_FRAC        = 8;
  localparam int MOMENT_W        = 64;
  localparam int AREA_W          = 48;
  localparam int CRISP_W         = 24;
  localparam int MUL_W           = 32;
  localparam int PROD_W          = 2 * MUL_W;
  localparam int IN_TDATA_W      = 80;
  localparam int OUT_TDATA_W     = CRISP_W;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRAC_BITS;

  localparam logic signed [CRISP_W-1:0] CRISP_MAX = {1'b0, {(CRISP_W-1){1'b1}}};
  localparam logic signed [CRISP_W-1:0] CRISP_MIN = {1'b1, {(CRISP_W-1){1'b0}}};

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_C,
    ST_MUL_D,
    ST_GEO,
    ST_SUMS,
    ST_MUL_P1,
    ST_MUL_P2,
    ST_MUL_AREA,
    ST_MUL_TLO,
    ST_MUL_THI,
    ST_MUL_AF,
    ST_SPLIT_T,
    ST_DIV6,
    ST_ACC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } tcd_state_t;

  typedef struct packed {
    logic                start;
    logic [MOMENT_W-1:0] num;
    logic [AREA_W-1:0]   den;
  } tcd_div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [MOMENT_W-1:0] quo;
  } tcd_div_resp_t;

endpackage

`default_nettype wire

>>> rtl/tcd_div.sv
// Signed restoring divider producing one quotient bit per cycle for the final centroid.
`default_nettype none

module tcd_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tcd_pkg::tcd_div_req_t  req,
  output tcd_pkg::tcd_div_resp_t resp
);
  import tcd_pkg::*;

  localparam int CNT_W = $clog2(MOMENT_W + 1);

  logic                busy_r;
  logic                done_r;
  logic                neg_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [MOMENT_W-1:0] quo_r;
  logic [AREA_W-1:0]   rem_r;
  logic [AREA_W-1:0]   den_r;

  logic                num_neg;
  logic                den_neg;
  logic [MOMENT_W-1:0] num_mag;
  logic [AREA_W-1:0]   den_mag;
  logic [AREA_W:0]     trial;
  logic [AREA_W:0]     trial_sub;
  logic                fits;

  assign num_neg   = req.num[MOMENT_W-1];
  assign den_neg   = req.den[AREA_W-1];
  assign num_mag   = num_neg ? (MOMENT_W'(0) - req.num) : req.num;
  assign den_mag   = den_neg ? (AREA_W'(0) - req.den) : req.den;
  assign trial     = {rem_r, quo_r[MOMENT_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign fits      = !trial_sub[AREA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MOMENT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      quo_r <= num_mag;
      rem_r <= '0;
      den_r <= den_mag;
      neg_r <= num_neg ^ den_neg;
    end else if (busy_r) begin
      quo_r <= {quo_r[MOMENT_W-2:0], fits};
      rem_r <= fits ? trial_sub[AREA_W-1:0] : trial[AREA_W-1:0];
    end
  end

  assign resp.busy = busy_r;
  assign resp.done = done_r;
  assign resp.quo  = neg_r ? (MOMENT_W'(0) - quo_r) : quo_r;

endmodule

`default_nettype wire

>>> rtl/trapezoid_centroid_defuzzifier_core.sv
// Centroid defuzzifier over clipped trapezoidal sets, built around one shared multiplier.
//
// Each input word carries one fuzzy set of an output variable; the block clips the trapezoid
// at the firing level and adds its area and first moment to two running sums, and on the word
// marked with in_tlast it returns the centroid (moment over area, 8 fraction bits, truncated
// toward zero and saturated to 24 bits), flagging a zero total area on out_tuser with a zero
// value. Eight products pass one after another through a single registered 32x32 signed
// multiplier, and the division of each set's moment term by six runs one byte per cycle. The
// final set of a variable also runs the divider, which resolves one quotient bit per cycle.
// in_tready is high only while the block waits for a word; a finished result sits in the
// output register, so the next variable's sets are taken while it waits to be read.
`default_nettype none

module trapezoid_centroid_defuzzifier_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // firing_level[15:0], core_left[31:16], core_right[47:32], slope_left[62:48],
  // slope_right[77:63], zero padding [79:78]
  input  logic [tcd_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // centroid[23:0]
  output logic [tcd_pkg::OUT_TDATA_W-1:0] out_tdata,
  // no_area[0]
  output logic                            out_tuser
);
  import tcd_pkg::*;

  localparam int CL_LSB     = LEVEL_W;
  localparam int CR_LSB     = CL_LSB + COORD_BITS;
  localparam int SL_LSB     = CR_LSB + COORD_BITS;
  localparam int SR_LSB     = SL_LSB + SLOPE_BITS;
  localparam int FOOT_W     = COORD_BITS + 2;
  localparam int DIFF_W     = COORD_BITS + 3;
  localparam int C_W        = SLOPE_BITS + GEO_FRAC;
  localparam int CSH        = LEVEL_FRAC_BITS - GEO_FRAC;
  localparam int A_W        = DIFF_W + GEO_FRAC;
  localparam int S_W        = A_W + 2;
  localparam int ASET_W     = A_W + 1;
  localparam int P_W        = 56;
  localparam int TSPLIT     = 24;
  localparam int T_W        = 48;
  localparam int AF_W       = 48;
  localparam int DIV6_STEPS = T_W / 8;
  localparam int D6_X_W     = 11;
  localparam int D6_M_W     = 21;
  localparam int DIV6_SHIFT = 12;
  localparam int DIV6_RECIP = 683;
  localparam int DIV6_DIVISOR = 6;

  tcd_state_t state_r, state_nxt;

  logic signed [COORD_BITS-1:0] in_cl, in_cr;
  logic [LEVEL_W-1:0]           in_level;
  logic [SLOPE_BITS-1:0]        in_sl, in_sr;

  logic [LEVEL_W-1:0]           lvl_r;
  logic signed [FOOT_W-1:0]     f_r, r_r;
  logic [SLOPE_BITS-1:0]        sl_r, sr_r;
  logic                         last_r;
  logic [C_W-1:0]               c_r;
  logic signed [A_W-1:0]        a_r;
  logic [A_W-1:0]               b_r;
  logic signed [S_W-1:0]        s1_r, s2_r, s3_r;
  logic signed [P_W-1:0]        p_r;
  logic signed [ASET_W-1:0]     area_r;
  logic signed [PROD_W-1:0]     t_r;
  logic signed [AF_W-1:0]       af_r;
  logic [T_W-1:0]               tmag_r, q6_r;
  logic                         tneg_r;
  logic [2:0]                   rem6_r, cnt6_r;
  logic [MOMENT_W-1:0]          moment_sum_r;
  logic [AREA_W-1:0]            area_sum_r;
  logic signed [CRISP_W-1:0]    res_r;
  logic                         noarea_r;
  logic                         out_tvalid_r;
  logic [OUT_TDATA_W-1:0]       out_tdata_r;
  logic                         out_tuser_r;

  logic signed [MUL_W-1:0]      mul_a, mul_b, lvl_ext;
  logic signed [PROD_W-1:0]     mul_p, prod_r;
  logic signed [DIFF_W-1:0]     diff_rf, diff_abs;
  logic [C_W-1:0]               d_w;
  logic signed [T_W-1:0]        t_val;
  logic [D6_X_W-1:0]            d6_x, d6_rem;
  logic [D6_M_W-1:0]            d6_m;
  logic [7:0]                   d6_q;
  logic signed [MOMENT_W-1:0]   q6_s, mom;
  logic signed [MOMENT_W-1:0]   quo_s;
  logic                         area_zero, out_free, out_load, acc_en;
  tcd_div_req_t                 div_req;
  tcd_div_resp_t                div_resp;

  assign in_level = in_tdata[0 +: LEVEL_W];
  assign in_cl    = signed'(in_tdata[CL_LSB +: COORD_BITS]);
  assign in_cr    = signed'(in_tdata[CR_LSB +: COORD_BITS]);
  assign in_sl    = in_tdata[SL_LSB +: SLOPE_BITS];
  assign in_sr    = in_tdata[SR_LSB +: SLOPE_BITS];

  assign lvl_ext   = signed'(MUL_W'(lvl_r));
  assign mul_p     = mul_a * mul_b;
  assign diff_rf   = DIFF_W'(r_r) - DIFF_W'(f_r);
  assign diff_abs  = diff_rf[DIFF_W-1] ? (DIFF_W'(0) - diff_rf) : diff_rf;
  assign d_w       = prod_r[CSH +: C_W];
  assign t_val     = signed'(t_r[LEVEL_FRAC_BITS +: T_W]);
  assign d6_x      = {rem6_r, tmag_r[T_W-1 -: 8]};
  assign d6_m      = D6_M_W'(d6_x) * D6_M_W'(DIV6_RECIP);
  assign d6_q      = d6_m[DIV6_SHIFT +: 8];
  assign d6_rem    = d6_x - D6_X_W'(d6_q) * D6_X_W'(DIV6_DIVISOR);
  assign q6_s      = tneg_r ? (MOMENT_W'(0) - signed'(MOMENT_W'(q6_r)))
                            : signed'(MOMENT_W'(q6_r));
  assign mom       = q6_s + MOMENT_W'(af_r);
  assign quo_s     = signed'(div_resp.quo);
  assign area_zero = (area_sum_r == '0);
  assign out_free  = !out_tvalid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_tvalid) state_nxt = ST_MUL_C;
      ST_MUL_C:     state_nxt = ST_MUL_D;
      ST_MUL_D:     state_nxt = ST_GEO;
      ST_GEO:       state_nxt = ST_SUMS;
      ST_SUMS:      state_nxt = ST_MUL_P1;
      ST_MUL_P1:    state_nxt = ST_MUL_P2;
      ST_MUL_P2:    state_nxt = ST_MUL_AREA;
      ST_MUL_AREA:  state_nxt = ST_MUL_TLO;
      ST_MUL_TLO:   state_nxt = ST_MUL_THI;
      ST_MUL_THI:   state_nxt = ST_MUL_AF;
      ST_MUL_AF:    state_nxt = ST_SPLIT_T;
      ST_SPLIT_T:   state_nxt = ST_DIV6;
      ST_DIV6:      if (cnt6_r == 3'(DIV6_STEPS - 1)) state_nxt = ST_ACC;
      ST_ACC:       state_nxt = last_r ? ST_DIV_START : ST_IDLE;
      ST_DIV_START: state_nxt = area_zero ? ST_EMIT : ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_resp.done) state_nxt = ST_EMIT;
      ST_EMIT:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs and multiplier operand selection.
  always_comb begin
    in_tready     = 1'b0;
    acc_en        = 1'b0;
    out_load      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = moment_sum_r << OUT_FRAC_BITS;
    div_req.den   = area_sum_r;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_r)
      ST_IDLE:      in_tready = 1'b1;
      ST_MUL_C: begin
        mul_a = lvl_ext;
        mul_b = signed'(MUL_W'(sl_r));
      end
      ST_MUL_D: begin
        mul_a = lvl_ext;
        mul_b = signed'(MUL_W'(sr_r));
      end
      ST_MUL_P1: begin
        mul_a = MUL_W'(a_r);
        mul_b = MUL_W'(s1_r);
      end
      ST_MUL_P2: begin
        mul_a = signed'(MUL_W'(b_r));
        mul_b = MUL_W'(s2_r);
      end
      ST_MUL_AREA: begin
        mul_a = MUL_W'(s3_r);
        mul_b = lvl_ext;
      end
      ST_MUL_TLO: begin
        mul_a = signed'(MUL_W'(p_r[GEO_FRAC +: TSPLIT]));
        mul_b = lvl_ext;
      end
      ST_MUL_THI: begin
        mul_a = MUL_W'(signed'(p_r[P_W-1:GEO_FRAC+TSPLIT]));
        mul_b = lvl_ext;
      end
      ST_MUL_AF: begin
        mul_a = MUL_W'(area_r);
        mul_b = MUL_W'(f_r);
      end
      ST_ACC:       acc_en = 1'b1;
      ST_DIV_START: div_req.start = !area_zero;
      ST_EMIT:      out_load = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
  end

  // Per-set datapath, one step per state.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          lvl_r  <= (in_level > LEVEL_ONE) ? LEVEL_ONE : in_level;
          f_r    <= FOOT_W'(in_cl) - signed'(FOOT_W'(in_sl));
          r_r    <= FOOT_W'(in_cr) + signed'(FOOT_W'(in_sr));
          sl_r   <= in_sl;
          sr_r   <= in_sr;
          last_r <= in_tlast;
        end
      end
      ST_MUL_D:    c_r <= prod_r[CSH +: C_W];
      ST_GEO: begin
        a_r <= signed'({diff_rf, {GEO_FRAC{1'b0}}}) - signed'(A_W'(c_r))
               - signed'(A_W'(d_w));
        b_r <= {diff_abs, {GEO_FRAC{1'b0}}};
      end
      ST_SUMS: begin
        s1_r <= signed'(S_W'({c_r, 1'b0})) + S_W'(a_r) + signed'(S_W'(b_r));
        s2_r <= signed'(S_W'(c_r)) + signed'(S_W'(b_r));
        s3_r <= S_W'(a_r) + signed'(S_W'(b_r));
      end
      ST_MUL_P2:   p_r <= prod_r[P_W-1:0];
      ST_MUL_AREA: p_r <= p_r + prod_r[P_W-1:0];
      ST_MUL_TLO:  area_r <= prod_r[LEVEL_FRAC_BITS+1 +: ASET_W];
      ST_MUL_THI:  t_r <= prod_r;
      ST_MUL_AF:   t_r <= t_r + (prod_r <<< TSPLIT);
      ST_SPLIT_T: begin
        af_r   <= prod_r[AF_W-1:0];
        tneg_r <= t_val[T_W-1];
        tmag_r <= t_val[T_W-1] ? (T_W'(0) - t_val) : t_val;
        q6_r   <= '0;
        rem6_r <= '0;
        cnt6_r <= '0;
      end
      ST_DIV6: begin
        tmag_r <= tmag_r << 8;
        q6_r   <= {q6_r[T_W-9:0], d6_q};
        rem6_r <= d6_rem[2:0];
        cnt6_r <= cnt6_r + 3'd1;
      end
      ST_DIV_START: begin
        if (area_zero) begin
          res_r    <= '0;
          noarea_r <= 1'b1;
        end
      end
      ST_DIV_WAIT: begin
        if (div_resp.done) begin
          noarea_r <= 1'b0;
          if (quo_s > MOMENT_W'(CRISP_MAX)) begin
            res_r <= CRISP_MAX;
          end else if (quo_s < MOMENT_W'(CRISP_MIN)) begin
            res_r <= CRISP_MIN;
          end else begin
            res_r <= quo_s[CRISP_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moment_sum_r <= '0;
      area_sum_r   <= '0;
    end else if (out_load) begin
      moment_sum_r <= '0;
      area_sum_r   <= '0;
    end else if (acc_en) begin
      moment_sum_r <= moment_sum_r + mom;
      area_sum_r   <= area_sum_r + AREA_W'(area_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= res_r;
      out_tuser_r <= noarea_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  tcd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .resp (div_resp)
  );

`ifndef NO_ASSERTIONS
  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_resp.busy)
    else $error("Divider started while still busy.");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_resp.done |-> (state_r == ST_DIV_WAIT))
    else $error("Divider finished outside the wait state.");

  a_noarea_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("Zero-area result carries a non-zero value.");

  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (moment_sum_r == '0) && (area_sum_r == '0))
    else $error("Running sums not cleared after a result word.");
`endif

endmodule

`default_nettype wire
